// ===== sv/dex_encoded_value_decoder_assert.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef DEX_ENCODED_VALUE_DECODER_ASSERT_SVH
`define DEX_ENCODED_VALUE_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define DEXD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("decoder assertion failed");
`define DEXD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("decoder forbidden condition seen");
`else
`define DEXD_ASSERT(lbl, clk, rst_n, prop)
`define DEXD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== sv/dexd_pkg.sv =====
package dexd_pkg;

  // Type codes carried in the low five bits of a header byte.
  localparam logic [4:0] KByte       = 5'h00;
  localparam logic [4:0] KShort      = 5'h02;
  localparam logic [4:0] KChar       = 5'h03;
  localparam logic [4:0] KInt        = 5'h04;
  localparam logic [4:0] KLong       = 5'h06;
  localparam logic [4:0] KFloat      = 5'h10;
  localparam logic [4:0] KDouble     = 5'h11;
  localparam logic [4:0] KString     = 5'h17;
  localparam logic [4:0] KType       = 5'h18;
  localparam logic [4:0] KField      = 5'h19;
  localparam logic [4:0] KMethod     = 5'h1A;
  localparam logic [4:0] KEnum       = 5'h1B;
  localparam logic [4:0] KArray      = 5'h1C;
  localparam logic [4:0] KAnnotation = 5'h1D;
  localparam logic [4:0] KNull       = 5'h1E;
  localparam logic [4:0] KBoolean    = 5'h1F;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegStringCount = 2'd0;
  localparam logic [1:0] RegTypeCount   = 2'd1;
  localparam logic [1:0] RegFieldCount  = 2'd2;
  localparam logic [1:0] RegMethodCount = 2'd3;

  // Default depth of the queue between the parser and the finisher.
  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [2:0] {
    ErrOk        = 3'd0,
    ErrArg       = 3'd1,
    ErrType      = 3'd2,
    ErrTrunc     = 3'd3,
    ErrIndex     = 3'd4,
    ErrContainer = 3'd5
  } dexd_err_e;

  // One finished value from the parser. When fin is set the raw bytes still
  // need extension and range checking; otherwise raw and err are final.
  typedef struct packed {
    logic [4:0]  kind;
    logic [3:0]  len;
    logic [63:0] raw;
    dexd_err_e   err;
    logic        fin;
  } dexd_job_t;

endpackage

// ===== sv/dexd_front.sv =====
`include "dex_encoded_value_decoder_assert.svh"

module dexd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_eod_i,
  output logic              push_o,
  output dexd_pkg::dexd_job_t push_job_o,
  input  logic              push_ready_i
);
  import dexd_pkg::*;

  logic        collecting_q, collecting_d;
  logic [4:0]  held_kind_q, held_kind_d;
  logic [3:0]  bytes_left_q, bytes_left_d;
  logic [2:0]  byte_pos_q, byte_pos_d;
  logic [3:0]  pay_len_q, pay_len_d;
  logic [63:0] assembly_q, assembly_d;

  logic        accept;
  logic [4:0]  hdr_kind;
  logic [2:0]  hdr_arg;
  logic [3:0]  hdr_len;
  dexd_err_e   hdr_err;
  logic [63:0] asm_new;
  logic [3:0]  left_new;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign hdr_kind   = in_byte_i[4:0];
  assign hdr_arg    = in_byte_i[7:5];
  assign asm_new    = assembly_q | ({56'd0, in_byte_i} << {byte_pos_q, 3'b000});
  assign left_new   = bytes_left_q - 4'd1;

  // Per-type argument check and payload length of a header byte.
  always_comb begin
    hdr_err = ErrOk;
    hdr_len = 4'd0;
    unique case (hdr_kind)
      KByte: begin
        if (hdr_arg != 3'd0) hdr_err = ErrArg;
        else hdr_len = 4'd1;
      end
      KArray, KAnnotation, KNull: begin
        if (hdr_arg != 3'd0) hdr_err = ErrArg;
      end
      KShort, KChar: begin
        if (hdr_arg >= 3'd2) hdr_err = ErrArg;
        else hdr_len = {1'b0, hdr_arg} + 4'd1;
      end
      KBoolean: begin
        if (hdr_arg >= 3'd2) hdr_err = ErrArg;
      end
      KInt, KFloat, KString, KType, KField, KMethod, KEnum: begin
        if (hdr_arg >= 3'd4) hdr_err = ErrArg;
        else hdr_len = {1'b0, hdr_arg} + 4'd1;
      end
      KLong, KDouble: begin
        hdr_len = {1'b0, hdr_arg} + 4'd1;
      end
      default: hdr_err = ErrType;
    endcase
  end

  always_comb begin
    collecting_d = collecting_q;
    held_kind_d  = held_kind_q;
    bytes_left_d = bytes_left_q;
    byte_pos_d   = byte_pos_q;
    pay_len_d    = pay_len_q;
    assembly_d   = assembly_q;
    push_o       = 1'b0;
    push_job_o   = '{kind: hdr_kind, len: 4'd0, raw: 64'd0, err: ErrOk, fin: 1'b0};
    if (accept) begin
      if (!collecting_q) begin
        if (hdr_err != ErrOk) begin
          push_o         = 1'b1;
          push_job_o.err = hdr_err;
        end else if (hdr_len == 4'd0) begin
          push_o = 1'b1;
          if (hdr_kind == KArray || hdr_kind == KAnnotation) begin
            push_job_o.err = ErrContainer;
          end else if (hdr_kind == KBoolean) begin
            push_job_o.raw = {61'd0, hdr_arg};
          end
        end else if (in_eod_i) begin
          push_o         = 1'b1;
          push_job_o.err = ErrTrunc;
        end else begin
          collecting_d = 1'b1;
          held_kind_d  = hdr_kind;
          pay_len_d    = hdr_len;
          bytes_left_d = hdr_len;
          byte_pos_d   = 3'd0;
          assembly_d   = 64'd0;
        end
      end else begin
        assembly_d       = asm_new;
        byte_pos_d       = byte_pos_q + 3'd1;
        bytes_left_d     = left_new;
        push_job_o.kind  = held_kind_q;
        if (left_new == 4'd0) begin
          push_o         = 1'b1;
          push_job_o.len = pay_len_q;
          push_job_o.raw = asm_new;
          push_job_o.fin = 1'b1;
          collecting_d   = 1'b0;
        end else if (in_eod_i) begin
          push_o         = 1'b1;
          push_job_o.err = ErrTrunc;
          collecting_d   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      held_kind_q  <= 5'd0;
      bytes_left_q <= 4'd0;
      byte_pos_q   <= 3'd0;
      pay_len_q    <= 4'd0;
      assembly_q   <= 64'd0;
    end else begin
      collecting_q <= collecting_d;
      held_kind_q  <= held_kind_d;
      bytes_left_q <= bytes_left_d;
      byte_pos_q   <= byte_pos_d;
      pay_len_q    <= pay_len_d;
      assembly_q   <= assembly_d;
    end
  end

  // While gathering payload there is always at least one byte still owed.
  `DEXD_ASSERT(a_front_left, clk_i, rst_ni, collecting_q |-> (bytes_left_q != 4'd0))

endmodule

// ===== sv/dexd_queue.sv =====
`include "dex_encoded_value_decoder_assert.svh"

module dexd_queue #(
  parameter int unsigned Depth = dexd_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dexd_pkg::dexd_job_t push_job_i,
  output logic                ready_o,
  output logic                valid_o,
  output dexd_pkg::dexd_job_t head_o,
  input  logic                pop_i
);
  import dexd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dexd_job_t         slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign ready_o = (count_q != FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  // The parser never offers an entry it would lose to a full queue.
  `DEXD_ASSERT_NEVER(a_queue_overrun, clk_i, rst_ni, push_i && !ready_o)
  // An empty queue has its read and write pointers equal.
  `DEXD_ASSERT(a_queue_empty_ptrs, clk_i, rst_ni, (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))

endmodule

// ===== sv/dexd_back.sv =====
`include "dex_encoded_value_decoder_assert.svh"

module dexd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                job_valid_i,
  input  dexd_pkg::dexd_job_t job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [4:0]          out_kind_o,
  output logic [63:0]         out_value_o,
  output logic [2:0]          out_err_o
);
  import dexd_pkg::*;

  logic [31:0] string_cnt_q, type_cnt_q, field_cnt_q, method_cnt_q;
  logic        out_valid_q;
  logic [4:0]  out_kind_q;
  logic [63:0] out_value_q;
  dexd_err_e   out_err_q;

  logic [3:0]  len;
  logic [6:0]  len_bits;
  logic [63:0] v;
  logic [31:0] limit;
  logic        indexed;
  logic [63:0] fin_value;
  dexd_err_e   fin_err;

  assign job_pop_o = job_valid_i && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      string_cnt_q <= 32'd0;
      type_cnt_q   <= 32'd0;
      field_cnt_q  <= 32'd0;
      method_cnt_q <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStringCount: string_cnt_q <= cfg_wdata_i;
        RegTypeCount:   type_cnt_q   <= cfg_wdata_i;
        RegFieldCount:  field_cnt_q  <= cfg_wdata_i;
        RegMethodCount: method_cnt_q <= cfg_wdata_i;
      endcase
    end
  end

  // Length is clamped to one to eight bytes before it drives any shift.
  always_comb begin
    len = job_i.len;
    if (len < 4'd1) len = 4'd1;
    if (len > 4'd8) len = 4'd8;
    len_bits = {len, 3'b000};
  end

  always_comb begin
    v       = job_i.raw;
    limit   = 32'd0;
    indexed = 1'b0;
    unique case (job_i.kind)
      KByte, KShort, KInt, KLong: begin
        if (len < 4'd8 && v[6'(len_bits - 7'd1)]) v = v | ({64{1'b1}} << len_bits);
      end
      KFloat: begin
        if (len <= 4'd4) begin
          v = {32'd0, 32'(v << {3'(4'd4 - len), 3'b000})};
        end
      end
      KDouble: v = v << {4'd8 - len, 3'b000};
      KString: begin
        limit   = string_cnt_q;
        indexed = 1'b1;
      end
      KType: begin
        limit   = type_cnt_q;
        indexed = 1'b1;
      end
      KField, KEnum: begin
        limit   = field_cnt_q;
        indexed = 1'b1;
      end
      KMethod: begin
        limit   = method_cnt_q;
        indexed = 1'b1;
      end
      default: ;
    endcase
    if (!job_i.fin) begin
      fin_value = job_i.raw;
      fin_err   = job_i.err;
    end else if (indexed && ((|v[63:32]) || (v[31:0] >= limit))) begin
      fin_value = 64'd0;
      fin_err   = ErrIndex;
    end else begin
      fin_value = v;
      fin_err   = ErrOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (job_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      out_kind_q  <= job_i.kind;
      out_value_q <= fin_value;
      out_err_q   <= fin_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;
  assign out_err_o   = out_err_q;

  // Every error beat reports a zero value.
  `DEXD_ASSERT(a_back_err_zero, clk_i, rst_ni,
               (out_valid_q && out_err_q != ErrOk) |-> (out_value_q == 64'd0))

endmodule

// ===== sv/dex_encoded_value_decoder.sv =====
// Encoded value decoder. Each input beat carries one byte of an encoded
// value stream on s_axis_tdata, with s_axis_tlast marking the last byte of
// the data section. A header byte holds the type code in its low five bits
// and an argument in its high three bits; the block checks the argument,
// gathers argument+1 payload bytes little-endian, extends or aligns them by
// type, range-checks table indices against the four count registers, and
// issues one output beat per value (or an error beat on early end of data,
// a bad argument, an unknown type, a container or an index out of range).
// The block takes one byte per clock cycle without a break as long as the
// output is drained; that rate is set by the byte parser, which updates its
// gathering state once per byte. The byte that completes a value writes its
// result into a slot of the result queue; from there it passes through the
// finishing stage into the output register once that register is free.
// A queue of QUEUE_DEPTH entries lets the parser keep accepting bytes while
// the output is stalled; once it fills, s_axis_tready drops. The count
// registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i and should
// only change while no value is in flight.
`include "dex_encoded_value_decoder_assert.svh"

module dex_encoded_value_decoder #(
  parameter int unsigned QUEUE_DEPTH = dexd_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration writes: 0 string count, 1 type count, 2 field count,
  // 3 method count.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,

  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_data

  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] value_bits, [66:64] error_code, rest zero
  output logic [4:0]  m_axis_tuser    // [4:0] kind_code
);
  import dexd_pkg::*;

  logic      push;
  dexd_job_t push_job;
  logic      q_ready;
  logic      q_valid;
  dexd_job_t q_head;
  logic      q_pop;
  logic [63:0] out_value;
  logic [2:0]  out_err;

  // Front: parses headers and gathers payload, one byte per beat.
  dexd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_eod_i     (s_axis_tlast),
    .push_o       (push),
    .push_job_o   (push_job),
    .push_ready_i (q_ready)
  );

  // Queue of parsed values between the parser and the finisher.
  dexd_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .pop_i      (q_pop)
  );

  // Back: sign/zero extension, float alignment, index checks, output register.
  dexd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_valid_i (q_valid),
    .job_i       (q_head),
    .job_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_value_o (out_value),
    .out_err_o   (out_err)
  );

  assign m_axis_tdata = {5'd0, out_err, out_value};

endmodule
